@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define CHK_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("check failed: always");

// Antecedent at one edge implies consequent at the next edge.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("check failed: next");

`endif

@@ hw/rtl/pwd_pkg.sv @@
// Package for the peer-wire deframer: constants, keyword table, shared types.
`default_nettype none

package pwd_pkg;

	localparam int BUFFER_BYTES_DEF = 16384;
	localparam int KW_BYTES         = 20;
	localparam int HS_TOTAL         = 68;
	localparam int LEN_BYTES        = 4;
	localparam int ID_OFFSET        = 4;
	localparam int OFF_W            = 33;
	localparam int LEN_W            = 32;
	localparam int RPT_W            = 15;

	// Handshake prefix: length 19, then "BitTorrent protocol"
	function automatic logic [7:0] kw_byte(input logic [4:0] idx);
		logic [7:0] val;
		case (idx)
			5'd0:    val = 8'd19;
			5'd1:    val = 8'h42; // B
			5'd2:    val = 8'h69; // i
			5'd3:    val = 8'h74; // t
			5'd4:    val = 8'h54; // T
			5'd5:    val = 8'h6f; // o
			5'd6:    val = 8'h72; // r
			5'd7:    val = 8'h72; // r
			5'd8:    val = 8'h65; // e
			5'd9:    val = 8'h6e; // n
			5'd10:   val = 8'h74; // t
			5'd11:   val = 8'h20; // space
			5'd12:   val = 8'h70; // p
			5'd13:   val = 8'h72; // r
			5'd14:   val = 8'h6f; // o
			5'd15:   val = 8'h74; // t
			5'd16:   val = 8'h6f; // o
			5'd17:   val = 8'h63; // c
			5'd18:   val = 8'h6f; // o
			5'd19:   val = 8'h6c; // l
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             first;
		logic             last;
		logic             hs;
		logic             id_valid;
		logic [7:0]       id;
		logic [LEN_W-1:0] length;
	} frame_info_t;

	typedef struct packed {
		logic             valid;
		logic [RPT_W-1:0] bytes;
		logic             all_done;
	} report_t;

endpackage

`default_nettype wire

@@ hw/rtl/pwd_frame.sv @@
// Message framing state: offset, keyword match, length prefix and type byte.
`default_nettype none

module pwd_frame import pwd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  data,
	output frame_info_t      info
);

	logic [OFF_W-1:0] offset_q;
	logic [LEN_W-1:0] length_q;
	logic             kw_match_q;
	logic             hs_q;
	logic [7:0]       id_q;

	logic             in_kw;
	logic             kw_hit;
	logic             kw_match_n;
	logic             hs_n;
	logic [LEN_W-1:0] length_n;
	logic [7:0]       id_n;
	logic             last;
	logic             id_valid;

	always_comb begin
		in_kw      = offset_q < OFF_W'(KW_BYTES);
		kw_hit     = data == kw_byte(offset_q[4:0]);
		kw_match_n = kw_match_q && !(in_kw && !kw_hit);
		hs_n       = hs_q || (in_kw && kw_match_q && kw_hit
			&& offset_q == OFF_W'(KW_BYTES - 1));
		length_n   = (offset_q < OFF_W'(LEN_BYTES)) ? {length_q[LEN_W-9:0], data} : length_q;
		id_n       = (offset_q == OFF_W'(ID_OFFSET)) ? data : id_q;
		if (hs_n) begin
			last = offset_q == OFF_W'(HS_TOTAL - 1);
		end else begin
			last = offset_q >= OFF_W'(LEN_BYTES - 1)
				&& (offset_q - OFF_W'(LEN_BYTES - 1)) == {1'b0, length_n};
		end
		id_valid = offset_q >= OFF_W'(ID_OFFSET) && !hs_n;
	end

	assign info.offset   = offset_q;
	assign info.first    = offset_q == '0;
	assign info.last     = last;
	assign info.hs       = hs_n;
	assign info.id_valid = id_valid;
	assign info.id       = id_valid ? id_n : 8'h00;
	assign info.length   = hs_n ? '0 : length_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			length_q   <= '0;
			kw_match_q <= 1'b1;
			hs_q       <= 1'b0;
			id_q       <= 8'h00;
		end else if (advance) begin
			if (last) begin
				offset_q   <= '0;
				length_q   <= '0;
				kw_match_q <= 1'b1;
				hs_q       <= 1'b0;
				id_q       <= 8'h00;
			end else begin
				offset_q   <= offset_q + OFF_W'(1);
				length_q   <= length_n;
				kw_match_q <= kw_match_n;
				hs_q       <= hs_n;
				id_q       <= id_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/pwd_acct.sv @@
// Buffer accounting: bytes held, end of last complete message, report on end of buffer.
`default_nettype none

module pwd_acct import pwd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire logic last,
	input  wire logic eob,
	output report_t   report
);

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

	logic [CNT_W-1:0]       total_q;
	logic [CNT_W-1:0]       mark_q;
	logic [CNT_W-1:0]       total_inc;
	logic [CNT_W-1:0]       mark_n;
	logic [CNT_W+RPT_W-1:0] mark_ext;

	always_comb begin
		// saturates once the buffer is full
		total_inc = (total_q < CNT_W'(BUFFER_BYTES)) ? total_q + CNT_W'(1) : total_q;
		mark_n    = last ? total_inc : mark_q;
		mark_ext  = {{RPT_W{1'b0}}, mark_n};
	end

	assign report.valid    = eob;
	assign report.bytes    = eob ? mark_ext[RPT_W-1:0] : '0;
	assign report.all_done = eob && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			mark_q  <= '0;
		end else if (advance) begin
			if (eob) begin
				// unfinished tail carries over into the next buffer
				total_q <= (total_inc >= mark_n) ? total_inc - mark_n : '0;
				mark_q  <= '0;
			end else begin
				total_q <= total_inc;
				mark_q  <= mark_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/peer_wire_message_deframer_core.sv @@
// Peer-wire message deframer: marks message boundaries in a received byte stream.
//
// Input channel: in_valid / in_stall with data_byte and end_of_buffer, one
// byte per transfer. Output channel: out_valid / out_stall with one result
// per input byte: offset in message, first/last marks, handshake flag,
// message id and length prefix, and on end-of-buffer bytes a report of the
// bytes held in complete messages.
// A byte taken into the input stage is decoded there and registered in the
// result register, which drives the outputs. Throughput: one byte per cycle
// while the receiver does not stall; the decode is a single pass of compare,
// counter and shift logic between the input stage and the result register.
// Reset clears both stages and the framing state: the first byte after reset
// starts a message and the buffer count starts at zero.
// When the receiver stalls, the held result stays put; the input stage keeps
// one further byte and in_stall rises only when both stages are full.
`default_nettype none

module peer_wire_message_deframer_core import pwd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               end_of_buffer,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              byte_out,
	output logic [OFF_W-1:0]        msg_offset,
	output logic                    first_byte,
	output logic                    last_byte,
	output logic                    handshake_seen,
	output logic                    id_valid,
	output logic [7:0]              msg_id,
	output logic [LEN_W-1:0]        msg_length,
	output logic                    report_valid,
	output logic [RPT_W-1:0]        complete_bytes,
	output logic                    all_complete
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eob_s1;
	logic        advance;

	frame_info_t info;
	report_t     report;

	logic             out_valid_q;
	logic [7:0]       byte_q;
	frame_info_t      info_q;
	report_t          report_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	pwd_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.data    (byte_s1),
		.info    (info)
	);

	pwd_acct #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_acct (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.last    (info.last),
		.eob     (eob_s1),
		.report  (report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q   <= byte_s1;
			info_q   <= info;
			report_q <= report;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_out       = byte_q;
	assign msg_offset     = info_q.offset;
	assign first_byte     = info_q.first;
	assign last_byte      = info_q.last;
	assign handshake_seen = info_q.hs;
	assign id_valid       = info_q.id_valid;
	assign msg_id         = info_q.id;
	assign msg_length     = info_q.length;
	assign report_valid   = report_q.valid;
	assign complete_bytes = report_q.bytes;
	assign all_complete   = report_q.all_done;

endmodule

`default_nettype wire

@@ hw/rtl/pwd_checker.sv @@
// Port-level checks for the peer-wire deframer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module pwd_checker import pwd_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [7:0]         data_byte,
	input wire logic               end_of_buffer,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [7:0]         byte_out,
	input wire logic [OFF_W-1:0]   msg_offset,
	input wire logic               first_byte,
	input wire logic               last_byte,
	input wire logic               handshake_seen,
	input wire logic               id_valid,
	input wire logic [7:0]         msg_id,
	input wire logic [LEN_W-1:0]   msg_length,
	input wire logic               report_valid,
	input wire logic [RPT_W-1:0]   complete_bytes,
	input wire logic               all_complete
);

	// a stalled result stays offered
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// after a completed message the next result starts a new one
	`CHK_NEXT(a_first_after_last, clk, arst_n, out_valid && !out_stall && last_byte, !out_valid || first_byte)

	// report fields only carry data on end-of-buffer bytes
	`CHK_ALWAYS(a_report_idle, clk, arst_n, !out_valid || report_valid || (complete_bytes == '0 && !all_complete))

	// a buffer ends on a boundary exactly when its last byte closes a message
	`CHK_ALWAYS(a_boundary, clk, arst_n, !out_valid || !report_valid || (all_complete == last_byte))

	// handshakes have no id and no length prefix
	`CHK_ALWAYS(a_hs_fields, clk, arst_n, !out_valid || !handshake_seen || (!id_valid && msg_id == 8'h00 && msg_length == '0))

endmodule

bind peer_wire_message_deframer_core pwd_checker u_pwd_checker (.*);

`default_nettype wire
